/* hdl/tfv_pkg.sv */
package tfv_pkg;

  // Frame layout
  localparam int unsigned FRAME_OVERHEAD = 7;
  localparam int unsigned CNT_W          = 10;
  localparam int unsigned LEN_W          = CNT_W + 1;

  localparam logic [CNT_W-1:0] COUNT_MAX   = '1;
  localparam logic [CNT_W-1:0] POS_MAGIC0  = 10'd0;
  localparam logic [CNT_W-1:0] POS_MAGIC1  = 10'd1;
  localparam logic [CNT_W-1:0] POS_VERSION = 10'd2;
  localparam logic [CNT_W-1:0] POS_TYPE    = 10'd3;
  localparam logic [CNT_W-1:0] POS_SIZE    = 10'd4;
  localparam logic [CNT_W-1:0] POS_BODY    = 10'd5;
  localparam logic [CNT_W-1:0] POS_RX_LO   = 10'd11;
  localparam logic [CNT_W-1:0] POS_RX_HI   = 10'd12;
  localparam logic [CNT_W-1:0] POS_FR_LO   = 10'd13;
  localparam logic [CNT_W-1:0] POS_FR_HI   = 10'd14;

  localparam logic [7:0] MAGIC_0 = 8'h54;  // 'T'
  localparam logic [7:0] MAGIC_1 = 8'h4D;  // 'M'

  // CRC-16/CCITT
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_LENGTH  = 3'd1;
  localparam logic [2:0] ST_HEADER  = 3'd2;
  localparam logic [2:0] ST_VERSION = 3'd3;
  localparam logic [2:0] ST_TYPE    = 3'd4;
  localparam logic [2:0] ST_CRC     = 3'd5;
  localparam logic [2:0] ST_MASK    = 3'd6;

  // Register map
  localparam logic [1:0] REG_VERSION   = 2'd0;
  localparam logic [1:0] REG_TYPES     = 2'd1;
  localparam logic [1:0] REG_SIZES     = 2'd2;
  localparam logic [1:0] REG_MAX_LEN   = 2'd3;

  localparam logic [7:0]  RST_VERSION = 8'd1;
  localparam logic [31:0] RST_TYPES   = 32'h0302_0100;
  localparam logic [31:0] RST_SIZES   = 32'h0000_0000;
  localparam logic [8:0]  RST_MAX_LEN = 9'd262;

  typedef struct packed {
    logic [7:0]  expected_version;
    logic [31:0] type_codes;
    logic [31:0] body_sizes;
    logic [8:0]  max_frame_length;
  } tfv_cfg_t;

  typedef struct packed {
    logic       is_status;
    logic [7:0] body_byte;
    logic [7:0] body_offset;
    logic [2:0] status;
    logic [7:0] packet_type;
    logic [7:0] frame_version;
  } tfv_result_t;

  // One byte through the MSB-first CRC, eight shift steps unrolled
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* hdl/telemetry_frame_validator_top.sv */
// Streaming validator for framed telemetry packets. Bytes enter one per
// transfer with is_last_i on the final byte; the frame is 'T','M', version,
// type, size byte, body and a little-endian CRC-16/CCITT (init 0xFFFF, poly
// 0x1021) over all preceding bytes. Each body byte leaves as a result with
// its offset; the last byte gives one status result (0 ok, 1 length,
// 2 header, 3 version, 4 type, 5 crc, 6 source masks). One byte is taken
// every clock cycle while results are taken: an input register feeds a single
// pass of CRC and check logic into an output register. The user must write
// registers through cfg_we_i/cfg_index_i/cfg_wdata_i only while no frame is
// in flight; the block itself does not enforce this. After reset all body
// sizes are zero, so every frame that passes the length, header and version
// checks reports a type error until they are written.
module telemetry_frame_validator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  frame_byte_i,
  input  logic        is_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        is_status_o,
  output logic [7:0]  body_byte_o,
  output logic [7:0]  body_offset_o,
  output logic [2:0]  status_o,
  output logic [7:0]  packet_type_o,
  output logic [7:0]  frame_version_o
);

  tfv_pkg::tfv_cfg_t    cfg_q;
  tfv_pkg::tfv_result_t res_d, res_out;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       out_free;
  logic       adv;
  logic       has_res;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.expected_version <= tfv_pkg::RST_VERSION;
      cfg_q.type_codes <= tfv_pkg::RST_TYPES;
      cfg_q.body_sizes <= tfv_pkg::RST_SIZES;
      cfg_q.max_frame_length <= tfv_pkg::RST_MAX_LEN;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        tfv_pkg::REG_VERSION: cfg_q.expected_version <= cfg_wdata_i[7:0];
        tfv_pkg::REG_TYPES:   cfg_q.type_codes <= cfg_wdata_i;
        tfv_pkg::REG_SIZES:   cfg_q.body_sizes <= cfg_wdata_i;
        tfv_pkg::REG_MAX_LEN: cfg_q.max_frame_length <= cfg_wdata_i[8:0];
        default: ;
      endcase
    end
  end

  // Input register: moves on whenever the output side can take a result
  assign adv        = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= frame_byte_i;
      in_last_q <= is_last_i;
    end
  end

  tfv_frame_proc u_proc (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .adv_i     (adv),
    .byte_i    (in_byte_q),
    .last_i    (in_last_q),
    .has_res_o (has_res),
    .res_o     (res_d)
  );

  tfv_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (adv && has_res),
    .res_i   (res_d),
    .ready_o (out_free),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .res_o   (res_out)
  );

  assign is_status_o     = res_out.is_status;
  assign body_byte_o     = res_out.body_byte;
  assign body_offset_o   = res_out.body_offset;
  assign status_o        = res_out.status;
  assign packet_type_o   = res_out.packet_type;
  assign frame_version_o = res_out.frame_version;

`ifndef SYNTHESIS
  a_status_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_status_o |-> body_byte_o == 8'd0 && body_offset_o == 8'd0)
    else $error("status result carries body fields");

  a_body_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_status_o |-> status_o == tfv_pkg::ST_OK &&
                                    packet_type_o == 8'd0 && frame_version_o == 8'd0)
    else $error("body result carries status fields");

  a_fail_clears_ids: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != tfv_pkg::ST_OK |-> packet_type_o == 8'd0 &&
                                                  frame_version_o == 8'd0)
    else $error("failed frame reports type or version");
`endif

endmodule

/* hdl/tfv_frame_proc.sv */
module tfv_frame_proc (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tfv_pkg::tfv_cfg_t    cfg_i,
  input  logic                 adv_i,
  input  logic [7:0]           byte_i,
  input  logic                 last_i,
  output logic                 has_res_o,
  output tfv_pkg::tfv_result_t res_o
);

  logic [tfv_pkg::CNT_W-1:0] count_q, count_d;
  logic [15:0]               crc_q, crc_d;
  logic [7:0]                dly0_q, dly0_d, dly1_q, dly1_d;
  logic                      hdr_q, hdr_d;
  logic [7:0]                ver_q, ver_d, type_q, type_d, size_q, size_d;
  logic [15:0]               rx_q, rx_d, fr_q, fr_d;

  logic [15:0]               crc_fed;
  logic [tfv_pkg::LEN_W-1:0] len;
  logic [tfv_pkg::LEN_W-1:0] body_end;
  logic                      in_body;
  logic                      found;
  logic [7:0]                mt_size;
  logic [2:0]                status;

  // CRC runs two bytes behind, so the trailing CRC bytes are never fed
  assign crc_fed = (count_q >= tfv_pkg::POS_MAGIC1 + 10'd1) ? tfv_pkg::crc16_byte(crc_q, dly1_q)
                                                           : crc_q;

  // Header and mask capture by frame position
  always_comb begin
    hdr_d = hdr_q;
    ver_d = ver_q;
    type_d = type_q;
    size_d = size_q;
    rx_d = rx_q;
    fr_d = fr_q;
    case (count_q)
      tfv_pkg::POS_MAGIC0:  hdr_d = (byte_i == tfv_pkg::MAGIC_0);
      tfv_pkg::POS_MAGIC1:  hdr_d = hdr_q && (byte_i == tfv_pkg::MAGIC_1);
      tfv_pkg::POS_VERSION: ver_d = byte_i;
      tfv_pkg::POS_TYPE:    type_d = byte_i;
      tfv_pkg::POS_SIZE:    size_d = byte_i;
      tfv_pkg::POS_RX_LO:   rx_d = {rx_q[15:8], byte_i};
      tfv_pkg::POS_RX_HI:   rx_d = {byte_i, rx_q[7:0]};
      tfv_pkg::POS_FR_LO:   fr_d = {fr_q[15:8], byte_i};
      tfv_pkg::POS_FR_HI:   fr_d = {byte_i, fr_q[7:0]};
      default: ;
    endcase
  end

  // Type lookup: scan downwards so the lowest matching slot wins
  always_comb begin
    found = 1'b0;
    mt_size = '0;
    for (int i = 3; i >= 0; i--) begin
      if (cfg_i.type_codes[8*i +: 8] == type_q) begin
        found = 1'b1;
        mt_size = cfg_i.body_sizes[8*i +: 8];
      end
    end
  end

  assign len = {1'b0, count_q} + 11'd1;

  // End-of-frame checks, first failure wins
  always_comb begin
    if (len < 11'(tfv_pkg::FRAME_OVERHEAD) || len > {2'b00, cfg_i.max_frame_length}) begin
      status = tfv_pkg::ST_LENGTH;
    end else if (!hdr_q) begin
      status = tfv_pkg::ST_HEADER;
    end else if (ver_q != cfg_i.expected_version) begin
      status = tfv_pkg::ST_VERSION;
    end else if (!found || mt_size == 8'd0) begin
      status = tfv_pkg::ST_TYPE;
    end else if (size_q != mt_size ||
                 len != {3'b000, mt_size} + 11'(tfv_pkg::FRAME_OVERHEAD)) begin
      status = tfv_pkg::ST_LENGTH;
    end else if ({byte_i, dly0_q} != crc_fed) begin
      status = tfv_pkg::ST_CRC;
    end else if ((fr_d & ~rx_d) != 16'h0000) begin
      status = tfv_pkg::ST_MASK;
    end else begin
      status = tfv_pkg::ST_OK;
    end
  end

  // Body window uses the size byte as received, not the configured size
  assign body_end = {1'b0, tfv_pkg::POS_BODY} + {3'b000, size_q};
  assign in_body  = !last_i && count_q >= tfv_pkg::POS_BODY && {1'b0, count_q} < body_end;

  // Result formation
  always_comb begin
    res_o = '0;
    has_res_o = 1'b0;
    if (last_i) begin
      has_res_o = 1'b1;
      res_o.is_status = 1'b1;
      res_o.status = status;
      if (status == tfv_pkg::ST_OK) begin
        res_o.packet_type = type_q;
        res_o.frame_version = ver_q;
      end
    end else if (in_body) begin
      has_res_o = 1'b1;
      res_o.body_byte = byte_i;
      res_o.body_offset = 8'(count_q - tfv_pkg::POS_BODY);
    end
  end

  // Next frame state: cleared on the last byte
  always_comb begin
    if (last_i) begin
      count_d = '0;
      crc_d = tfv_pkg::CRC_INIT;
      dly0_d = '0;
      dly1_d = '0;
    end else begin
      count_d = (count_q != tfv_pkg::COUNT_MAX) ? count_q + 10'd1 : count_q;
      crc_d = crc_fed;
      dly0_d = byte_i;
      dly1_d = dly0_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      crc_q <= tfv_pkg::CRC_INIT;
      dly0_q <= '0;
      dly1_q <= '0;
      hdr_q <= 1'b0;
      ver_q <= '0;
      type_q <= '0;
      size_q <= '0;
      rx_q <= '0;
      fr_q <= '0;
    end else if (adv_i) begin
      count_q <= count_d;
      crc_q <= crc_d;
      dly0_q <= dly0_d;
      dly1_q <= dly1_d;
      if (last_i) begin
        hdr_q <= 1'b0;
        ver_q <= '0;
        type_q <= '0;
        size_q <= '0;
        rx_q <= '0;
        fr_q <= '0;
      end else begin
        hdr_q <= hdr_d;
        ver_q <= ver_d;
        type_q <= type_d;
        size_q <= size_d;
        rx_q <= rx_d;
        fr_q <= fr_d;
      end
    end
  end

`ifndef SYNTHESIS
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && last_i |=> count_q == '0 && crc_q == tfv_pkg::CRC_INIT)
    else $error("frame state not cleared after last byte");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && !last_i && count_q != tfv_pkg::COUNT_MAX |=> count_q == $past(count_q) + 10'd1)
    else $error("byte count did not advance");

  a_hold_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_i |=> $stable(count_q) && $stable(crc_q))
    else $error("frame state changed without a transfer");
`endif

endmodule

/* hdl/tfv_out_reg.sv */
module tfv_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  tfv_pkg::tfv_result_t res_i,
  output logic                 ready_o,
  output logic                 valid_o,
  input  logic                 ready_i,
  output tfv_pkg::tfv_result_t res_o
);

  logic                 valid_q;
  tfv_pkg::tfv_result_t res_q;

  // Free when empty or being drained this cycle
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

/* sim/telemetry_frame_validator_top_tb.sv */
`timescale 1ns / 100ps

module telemetry_frame_validator_top_tb;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned RANDOM_ITEMS   = 100;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned MAX_PRINTED    = 40;

  typedef enum int {
    FR_GOOD,
    FR_SHORT,
    FR_HEADER,
    FR_VERSION,
    FR_TYPE,
    FR_SIZE_BYTE,
    FR_LEN,
    FR_CRC,
    FR_MASK,
    FR_NOISE,
    FR_LONG
  } frame_kind_e;

  // Frame checker model plus the queue of results still owed by the block
  class frame_scoreboard;
    logic [7:0]  exp_version;
    logic [31:0] type_codes;
    logic [31:0] body_sizes;
    logic [8:0]  max_len;

    logic [9:0]  byte_count;
    logic [15:0] crc;
    logic [7:0]  newest;
    logic [7:0]  older;
    logic        header_good;
    logic [7:0]  version_seen;
    logic [7:0]  type_seen;
    logic [7:0]  size_seen;
    logic [15:0] rx_mask;
    logic [15:0] fresh_mask;

    tfv_pkg::tfv_result_t owed_q[$];
    int unsigned          errors;

    function new();
      exp_version = tfv_pkg::RST_VERSION;
      type_codes  = tfv_pkg::RST_TYPES;
      body_sizes  = tfv_pkg::RST_SIZES;
      max_len     = tfv_pkg::RST_MAX_LEN;
      errors      = 0;
      clear_frame();
    endfunction

    // MSB-first CRC, one data bit per step
    static function logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
      logic fb;
      for (int k = 7; k >= 0; k--) begin
        fb = c[15] ^ b[k];
        c  = {c[14:0], 1'b0};
        if (fb) begin
          c = c ^ tfv_pkg::CRC_POLY;
        end
      end
      return c;
    endfunction

    function void clear_frame();
      byte_count   = '0;
      crc          = tfv_pkg::CRC_INIT;
      newest       = '0;
      older        = '0;
      header_good  = 1'b0;
      version_seen = '0;
      type_seen    = '0;
      size_seen    = '0;
      rx_mask      = '0;
      fresh_mask   = '0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        tfv_pkg::REG_VERSION: exp_version = data[7:0];
        tfv_pkg::REG_TYPES:   type_codes  = data;
        tfv_pkg::REG_SIZES:   body_sizes  = data;
        tfv_pkg::REG_MAX_LEN: max_len     = data[8:0];
        default: ;
      endcase
    endfunction

    // Checks in priority order, first failure wins
    function logic [2:0] judge(int len, logic [15:0] crc_rx);
      logic [7:0] size;
      logic       found;
      size  = '0;
      found = 1'b0;
      if (len < int'(tfv_pkg::FRAME_OVERHEAD) || len > int'(max_len)) return tfv_pkg::ST_LENGTH;
      if (!header_good) return tfv_pkg::ST_HEADER;
      if (version_seen != exp_version) return tfv_pkg::ST_VERSION;
      for (int i = 0; i < 4; i++) begin
        if (!found && type_codes[8*i +: 8] == type_seen) begin
          found = 1'b1;
          size  = body_sizes[8*i +: 8];
        end
      end
      if (!found || size == 8'd0) return tfv_pkg::ST_TYPE;
      if (size_seen != size || len != int'(size) + int'(tfv_pkg::FRAME_OVERHEAD)) begin
        return tfv_pkg::ST_LENGTH;
      end
      if (crc_rx != crc) return tfv_pkg::ST_CRC;
      if ((fresh_mask & ~rx_mask) != 16'd0) return tfv_pkg::ST_MASK;
      return tfv_pkg::ST_OK;
    endfunction

    // Called once per accepted input transfer
    function void note_input(logic [7:0] b, logic last);
      logic [9:0]           pos;
      tfv_pkg::tfv_result_t r;
      pos = byte_count;
      r   = '0;
      if (pos >= tfv_pkg::POS_VERSION) begin
        crc = crc_next(crc, older);
      end
      case (pos)
        tfv_pkg::POS_MAGIC0:  header_good = (b == tfv_pkg::MAGIC_0);
        tfv_pkg::POS_MAGIC1:  header_good = header_good && (b == tfv_pkg::MAGIC_1);
        tfv_pkg::POS_VERSION: version_seen = b;
        tfv_pkg::POS_TYPE:    type_seen = b;
        tfv_pkg::POS_SIZE:    size_seen = b;
        tfv_pkg::POS_RX_LO:   rx_mask[7:0] = b;
        tfv_pkg::POS_RX_HI:   rx_mask[15:8] = b;
        tfv_pkg::POS_FR_LO:   fresh_mask[7:0] = b;
        tfv_pkg::POS_FR_HI:   fresh_mask[15:8] = b;
        default: ;
      endcase
      if (last) begin
        r.is_status = 1'b1;
        r.status    = judge(int'(pos) + 1, {b, newest});
        if (r.status == tfv_pkg::ST_OK) begin
          r.packet_type   = type_seen;
          r.frame_version = version_seen;
        end
        owed_q.push_back(r);
        clear_frame();
      end else begin
        older  = newest;
        newest = b;
        if (pos != tfv_pkg::COUNT_MAX) begin
          byte_count = pos + 10'd1;
        end
        if (int'(pos) >= int'(tfv_pkg::POS_BODY) &&
            int'(pos) < int'(tfv_pkg::POS_BODY) + int'(size_seen)) begin
          r.body_byte   = b;
          r.body_offset = 8'(pos - tfv_pkg::POS_BODY);
          owed_q.push_back(r);
        end
      end
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= MAX_PRINTED) begin
        $display("MISMATCH: %s", msg);
      end
    endfunction

    function void compare_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) begin
        report($sformatf("%s got %0h, expected %0h", name, got, want));
      end
    endfunction

    // Called once per accepted output transfer
    function void check_result(tfv_pkg::tfv_result_t got);
      tfv_pkg::tfv_result_t want;
      if (owed_q.size() == 0) begin
        report($sformatf("result %h with nothing outstanding", got));
        return;
      end
      want = owed_q.pop_front();
      compare_field("is_status", 8'(got.is_status), 8'(want.is_status));
      compare_field("body_byte", got.body_byte, want.body_byte);
      compare_field("body_offset", got.body_offset, want.body_offset);
      compare_field("status", 8'(got.status), 8'(want.status));
      compare_field("packet_type", got.packet_type, want.packet_type);
      compare_field("frame_version", got.frame_version, want.frame_version);
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [31:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  frame_byte_i;
  logic        is_last_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        is_status_o;
  logic [7:0]  body_byte_o;
  logic [7:0]  body_offset_o;
  logic [2:0]  status_o;
  logic [7:0]  packet_type_o;
  logic [7:0]  frame_version_o;

  frame_scoreboard sb;
  int unsigned     sent_bytes;
  int unsigned     quiet_cycles;
  int unsigned     hold_left;
  bit              no_idle;
  bit              hold_req;

  telemetry_frame_validator_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .frame_byte_i    (frame_byte_i),
    .is_last_i       (is_last_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .is_status_o     (is_status_o),
    .body_byte_o     (body_byte_o),
    .body_offset_o   (body_offset_o),
    .status_o        (status_o),
    .packet_type_o   (packet_type_o),
    .frame_version_o (frame_version_o)
  );

  // 4 ns clock
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Transfer monitors
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      sb.note_input(frame_byte_i, is_last_i);
    end
    if (out_valid_o && out_ready_i) begin
      sb.check_result({is_status_o, body_byte_o, body_offset_o, status_o,
                       packet_type_o, frame_version_o});
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: random back-pressure, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= no_idle || ($urandom_range(99) >= 11);
    end
  end

  // One input transfer, with an occasional idle cycle in front
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (!no_idle && $urandom_range(99) < 11) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    frame_byte_i <= b;
    is_last_i    <= last;
    do @(posedge clk_i); while (!in_ready_o);
    sent_bytes++;
  endtask

  // Stop sending and wait until every owed result has been taken
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    sb.set_reg(idx, data);
  endtask

  task automatic set_config(input logic [7:0] ver, input logic [31:0] codes,
                            input logic [31:0] sizes, input logic [8:0] max_len);
    cfg_write(tfv_pkg::REG_VERSION, 32'(ver));
    cfg_write(tfv_pkg::REG_TYPES, codes);
    cfg_write(tfv_pkg::REG_SIZES, sizes);
    cfg_write(tfv_pkg::REG_MAX_LEN, 32'(max_len));
  endtask

  // Mostly small bodies, occasional zero, tiny or large sizes, some duplicate codes
  task automatic random_config();
    logic [31:0] codes;
    logic [31:0] sizes;
    logic [8:0]  max_len;
    int          k;
    codes = $urandom;
    if ($urandom_range(3) == 0) begin
      k = $urandom_range(1, 3);
      codes[8*k +: 8] = codes[7:0];
    end
    for (k = 0; k < 4; k++) begin
      case ($urandom_range(9))
        0:       sizes[8*k +: 8] = 8'd0;
        1:       sizes[8*k +: 8] = 8'($urandom_range(1, 9));
        2:       sizes[8*k +: 8] = 8'($urandom_range(25, 255));
        default: sizes[8*k +: 8] = 8'($urandom_range(10, 24));
      endcase
    end
    if ($urandom_range(1) == 0) begin
      max_len = tfv_pkg::RST_MAX_LEN;
    end else begin
      max_len = 9'($urandom_range(tfv_pkg::FRAME_OVERHEAD, tfv_pkg::RST_MAX_LEN));
    end
    set_config(8'($urandom), codes, sizes, max_len);
  endtask

  // Build one frame of the given kind against the current settings and send it
  task automatic send_frame(input frame_kind_e kind, input int pick = -1);
    logic [7:0]  fb[$];
    logic [7:0]  code;
    logic [7:0]  size;
    logic [7:0]  c;
    logic [15:0] crc;
    logic [15:0] rx;
    logic [15:0] fr;
    logic        known;
    int          idx;
    int          hit;
    int          k;
    int          n;
    fb   = {};
    code = '0;
    size = '0;
    // Choose a type; large bodies only now and then
    for (int tries = 0; tries < 8; tries++) begin
      idx  = (pick >= 0) ? pick : $urandom_range(3);
      code = sb.type_codes[8*idx +: 8];
      hit  = idx;
      for (k = idx; k >= 0; k--) begin
        if (sb.type_codes[8*k +: 8] == code) hit = k;
      end
      size = sb.body_sizes[8*hit +: 8];
      if (pick >= 0 || size <= 8'd40 || $urandom_range(7) == 0) break;
    end

    case (kind)
      FR_SHORT: begin
        n = $urandom_range(1, tfv_pkg::FRAME_OVERHEAD - 1);
        repeat (n) fb.push_back(8'($urandom));
      end
      FR_NOISE: begin
        n = $urandom_range(1, 40);
        repeat (n) fb.push_back(8'($urandom));
        if ($urandom_range(1) == 0) begin
          fb[0] = tfv_pkg::MAGIC_0;
          if (n > 1) fb[1] = tfv_pkg::MAGIC_1;
        end
      end
      FR_LONG: begin
        fb.push_back(tfv_pkg::MAGIC_0);
        fb.push_back(tfv_pkg::MAGIC_1);
        fb.push_back(sb.exp_version);
        fb.push_back(code);
        n = $urandom_range(1025, 1030);
        while (fb.size() < n) fb.push_back(8'($urandom));
      end
      default: begin
        fb.push_back(tfv_pkg::MAGIC_0);
        fb.push_back(tfv_pkg::MAGIC_1);
        fb.push_back(sb.exp_version);
        fb.push_back(code);
        fb.push_back(size);
        repeat (size) fb.push_back(8'($urandom));
        // Source masks: fresh must sit inside received unless a mask error is wanted
        if (size >= 8'd10) begin
          rx = 16'($urandom);
          fr = 16'($urandom) & rx;
          if (kind == FR_MASK) begin
            k = $urandom_range(15);
            rx[k] = 1'b0;
            fr[k] = 1'b1;
          end
          fb[tfv_pkg::POS_RX_LO] = rx[7:0];
          fb[tfv_pkg::POS_RX_HI] = rx[15:8];
          fb[tfv_pkg::POS_FR_LO] = fr[7:0];
          fb[tfv_pkg::POS_FR_HI] = fr[15:8];
        end
        case (kind)
          FR_HEADER: begin
            k = $urandom_range(1);
            fb[k] = fb[k] ^ 8'(1 << $urandom_range(7));
          end
          FR_VERSION: begin
            fb[tfv_pkg::POS_VERSION] = fb[tfv_pkg::POS_VERSION] ^ 8'($urandom_range(1, 255));
          end
          FR_TYPE: begin
            do begin
              c = 8'($urandom);
              known = 1'b0;
              for (k = 0; k < 4; k++) begin
                if (sb.type_codes[8*k +: 8] == c) known = 1'b1;
              end
            end while (known);
            fb[tfv_pkg::POS_TYPE] = c;
          end
          FR_SIZE_BYTE: begin
            fb[tfv_pkg::POS_SIZE] = fb[tfv_pkg::POS_SIZE] ^ 8'($urandom_range(1, 255));
          end
          FR_LEN: begin
            if (size != 8'd0 && $urandom_range(1) == 0) begin
              fb.delete(int'(tfv_pkg::POS_BODY));
            end else begin
              fb.insert(int'(tfv_pkg::POS_BODY), 8'($urandom));
            end
          end
          default: ;
        endcase
        // Little-endian CRC over everything so far
        crc = tfv_pkg::CRC_INIT;
        for (k = 0; k < fb.size(); k++) begin
          crc = frame_scoreboard::crc_next(crc, fb[k]);
        end
        fb.push_back(crc[7:0]);
        fb.push_back(crc[15:8]);
        if (kind == FR_CRC) begin
          k = fb.size() - 1 - $urandom_range(1);
          fb[k] = fb[k] ^ 8'(1 << $urandom_range(7));
        end
      end
    endcase

    for (k = 0; k < fb.size(); k++) begin
      send_byte(fb[k], k == fb.size() - 1);
    end
  endtask

  function automatic frame_kind_e pick_kind();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return FR_GOOD;
    if (r < 56) return FR_HEADER;
    if (r < 62) return FR_VERSION;
    if (r < 68) return FR_TYPE;
    if (r < 74) return FR_SIZE_BYTE;
    if (r < 80) return FR_LEN;
    if (r < 87) return FR_CRC;
    if (r < 93) return FR_MASK;
    if (r < 96) return FR_SHORT;
    return FR_NOISE;
  endfunction

  // Stimulus
  initial begin
    int unsigned start;
    int          nframes;
    sb           = new();
    sent_bytes   = 0;
    quiet_cycles = 0;
    hold_left    = 0;
    no_idle      = 1'b0;
    hold_req     = 1'b0;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = '0;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    frame_byte_i = '0;
    is_last_i    = 1'b0;
    out_ready_i  = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: all body sizes zero, so the good frame gets a type error and the short one a length error
    send_frame(FR_GOOD);
    send_frame(FR_SHORT);
    drain();

    // Small bodies, including ones too short to reach the mask bytes; the
    // receiver holds off at the start so the block fills and stalls its input
    set_config(8'hA5, 32'h7F80_0155, 32'h0105_0A10, tfv_pkg::RST_MAX_LEN);
    hold_req = 1'b1;
    send_frame(FR_GOOD, 0);
    send_frame(FR_GOOD, 3);
    send_frame(FR_GOOD, 2);
    send_frame(FR_MASK, 0);
    send_frame(FR_HEADER, 1);
    send_frame(FR_VERSION, 1);
    send_frame(FR_TYPE, 1);
    send_frame(FR_SIZE_BYTE, 1);
    send_frame(FR_LEN, 1);
    send_frame(FR_CRC, 1);
    send_frame(FR_SHORT);
    drain();

    // All codes alike, lowest index wins
    set_config(8'hFF, 32'hFFFF_FFFF, 32'h0A0B_0C0D, tfv_pkg::RST_MAX_LEN);
    send_frame(FR_GOOD, 2);
    send_frame(FR_LEN, 0);
    drain();

    // Tightest length limit, then a frame long enough to saturate the counter,
    // sent with no idling on either side
    set_config(8'h00, 32'h0000_0000, 32'hFFFF_FF0A, 9'(tfv_pkg::FRAME_OVERHEAD));
    send_frame(FR_GOOD, 0);
    no_idle = 1'b1;
    send_frame(FR_LONG, 0);
    drain();
    no_idle = 1'b0;

    // Random settings and frame mix
    start = sent_bytes;
    while (sent_bytes - start < RANDOM_ITEMS) begin
      random_config();
      nframes = $urandom_range(4, 8);
      for (int f = 0; f < nframes; f++) begin
        send_frame(pick_kind());
      end
      drain();
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
